### rtl/peak_hold_bar_decay_top_assert.svh
// Assertion macros used by the peak hold meter controller.
`ifndef PEAK_HOLD_BAR_DECAY_TOP_ASSERT_SVH
`define PEAK_HOLD_BAR_DECAY_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define PHBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the next cycle.
`define PHBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/phbd_pkg.sv
// Package: constants, types and codes of the peak hold bar meter.
package phbd_pkg;

	localparam int BANDS      = 64;
	localparam int LEVEL_BITS = 12;
	localparam int LVL_W      = LEVEL_BITS;
	localparam int BAND_AW    = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int REPORT_MAX = 64;
	localparam int REPORT_N   = (BANDS < REPORT_MAX) ? BANDS : REPORT_MAX;

	localparam int BAND_W    = 6;
	localparam int SAMPLE_W  = 17;
	localparam int OUT_LVL_W = 12;
	localparam int BH_W      = 12;
	localparam int HT_W      = 8;
	localparam int HOLD_W    = 8;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = SAMPLE_W + BH_W;
	localparam int SCALED_W  = PROD_W + 1 - FRAC_W;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [LVL_W-1:0]  LEVEL_MAX      = '1;
	localparam logic [HOLD_W-1:0] HOLD_MAX       = '1;
	localparam logic [FRAC_W-1:0] ROUND_ADD      = '1;
	localparam logic [BH_W-1:0]   BAR_HEIGHT_RST = BH_W'(256);
	localparam logic [HT_W-1:0]   HOLD_TICKS_RST = HT_W'(12);

	// Register index codes (address bit 2)
	localparam logic REG_BAR_HEIGHT = 1'b0;
	localparam logic REG_HOLD_TICKS = 1'b1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LD_RD,
		S_LD_WR,
		S_TK_RD,
		S_TK_RUN
	} state_t;

	typedef enum logic [1:0] {
		RD_BAND,
		RD_IDX,
		RD_NEXT
	} rd_sel_t;

	typedef struct packed {
		logic [LVL_W-1:0]  bar;
		logic [LVL_W-1:0]  peak;
		logic [LVL_W-1:0]  bar_step;
		logic [LVL_W-1:0]  peak_step;
		logic [HOLD_W-1:0] hold;
	} row_t;

	localparam row_t ROW_RST = '{
		bar:       LVL_W'(1),
		peak:      '0,
		bar_step:  LVL_W'(1),
		peak_step: LVL_W'(1),
		hold:      '0
	};

	typedef struct packed {
		logic [BH_W-1:0] bar_height;
		logic [HT_W-1:0] hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic    capture;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    ld_wr;
		logic    tk_wr;
		logic    out_load;
		logic    idx_clr;
		logic    idx_inc;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic idx_rep;
		logic idx_rep_last;
	} sts_t;

endpackage

### rtl/phbd_if.sv
// Stream interfaces for the meter input and result channels.
interface phbd_in_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [phbd_pkg::BAND_W-1:0]   band;
	logic [phbd_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output operation, output band, output sample, input ready);
	modport sink (input valid, input operation, input band, input sample, output ready);
endinterface

interface phbd_out_if;
	logic                          valid;
	logic                          ready;
	logic [phbd_pkg::BAND_W-1:0]    out_band;
	logic [phbd_pkg::OUT_LVL_W-1:0] bar_level;
	logic [phbd_pkg::OUT_LVL_W-1:0] peak_level;
	logic                          last;

	modport source (output valid, output out_band, output bar_level, output peak_level,
		output last, input ready);
	modport sink (input valid, input out_band, input bar_level, input peak_level,
		input last, output ready);
endinterface

### rtl/peak_hold_bar_decay_top.sv
// Top level of the per-band peak hold bar meter.
// Usage:
//   in_ch carries one transaction per operation: a load (band, Q1.16 sample)
//   or a timer tick. out_ch returns one result per reported band on a tick,
//   bands 0 up to 63 in order, with last set on the final one; a load returns none.
//   The APB port sets bar_height (address 0) and hold_ticks (address 4); write
//   it only while the meter is idle.
// Sequencing:
//   A load passes through accept, memory read and write back before the next item.
//   A tick passes through the accept, a priming read of the band memory, then, while
//   the receiver keeps up, each cycle writes back one band, loads the result register
//   and reads the next band through the state memory's separate read and write ports.
//   The first result is loaded with the write back of band 0, after the priming read.
// Stall: a receiver that holds off ready freezes the band sweep with the pending
//   result held in the output register; in_ch.ready returns as soon as the
//   sweep is done, even while the final result still waits.
// Reset: every band starts with bar 1, peak 0, steps 1, hold count 0, through
//   per-band valid flags; no clearing sweep runs, so items are taken at once.
module peak_hold_bar_decay_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [phbd_pkg::PADDR_W-1:0]  paddr,
	input  logic [phbd_pkg::PDATA_W-1:0]  pwdata,
	output logic [phbd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	phbd_in_if.sink                       in_ch,
	phbd_out_if.source                    out_ch
);

	phbd_pkg::cfg_t cfg;
	phbd_pkg::cmd_t cmd;
	phbd_pkg::sts_t sts;

	phbd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	phbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.operation),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	phbd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.in_band    (in_ch.band),
		.in_sample  (in_ch.sample),
		.sts        (sts),
		.out_band   (out_ch.out_band),
		.bar_level  (out_ch.bar_level),
		.peak_level (out_ch.peak_level),
		.last       (out_ch.last)
	);

endmodule

### rtl/phbd_cfg.sv
// APB configuration registers: bar height and hold tick count.
module phbd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [phbd_pkg::PADDR_W-1:0]  paddr,
	input  logic [phbd_pkg::PDATA_W-1:0]  pwdata,
	output logic [phbd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output phbd_pkg::cfg_t                cfg
);

	logic [phbd_pkg::BH_W-1:0] bar_height_q;
	logic [phbd_pkg::HT_W-1:0] hold_ticks_q;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_height_q <= phbd_pkg::BAR_HEIGHT_RST;
			hold_ticks_q <= phbd_pkg::HOLD_TICKS_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				phbd_pkg::REG_BAR_HEIGHT: bar_height_q <= pwdata[phbd_pkg::BH_W-1:0];
				phbd_pkg::REG_HOLD_TICKS: hold_ticks_q <= pwdata[phbd_pkg::HT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			phbd_pkg::REG_BAR_HEIGHT: prdata = phbd_pkg::PDATA_W'(bar_height_q);
			phbd_pkg::REG_HOLD_TICKS: prdata = phbd_pkg::PDATA_W'(hold_ticks_q);
			default:                  prdata = '0;
		endcase
	end

	assign cfg.bar_height = bar_height_q;
	assign cfg.hold_ticks = hold_ticks_q;

endmodule

### rtl/phbd_dp.sv
// Datapath: band state memory, sample scaling, fall update and result register.
module phbd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  phbd_pkg::cmd_t                  cmd,
	input  phbd_pkg::cfg_t                  cfg,
	input  logic [phbd_pkg::BAND_W-1:0]     in_band,
	input  logic [phbd_pkg::SAMPLE_W-1:0]   in_sample,
	output phbd_pkg::sts_t                  sts,
	output logic [phbd_pkg::BAND_W-1:0]     out_band,
	output logic [phbd_pkg::OUT_LVL_W-1:0]  bar_level,
	output logic [phbd_pkg::OUT_LVL_W-1:0]  peak_level,
	output logic                            last
);

	localparam int LVL_W   = phbd_pkg::LVL_W;
	localparam int BAND_AW = phbd_pkg::BAND_AW;

	function automatic logic [LVL_W-1:0] fall(input logic [LVL_W-1:0] lvl,
		input logic [LVL_W-1:0] step);
		return (lvl > step) ? lvl - step : '0;
	endfunction

	function automatic logic [LVL_W-1:0] grow(input logic [LVL_W-1:0] step);
		return (step != phbd_pkg::LEVEL_MAX) ? step + 1'b1 : step;
	endfunction

	logic [phbd_pkg::BAND_W-1:0]    band_q;
	logic                           band_ok_q;
	logic [phbd_pkg::SAMPLE_W-1:0]  sample_q;
	logic [phbd_pkg::PROD_W-1:0]    prod_s1;
	logic [BAND_AW-1:0]             idx_q;

	phbd_pkg::row_t                 mem [phbd_pkg::BANDS];
	logic [phbd_pkg::BANDS-1:0]     valid_q;
	phbd_pkg::row_t                 rdata_s;
	logic                           rvld_s;

	logic [BAND_AW-1:0]             rd_addr;
	logic [BAND_AW-1:0]             wr_addr;
	logic                           wr_en;
	phbd_pkg::row_t                 row_cur;
	phbd_pkg::row_t                 ld_row;
	phbd_pkg::row_t                 tk_row;
	phbd_pkg::row_t                 wdata;
	logic [phbd_pkg::PROD_W:0]      round_sum;
	logic [phbd_pkg::SCALED_W-1:0]  scaled;
	logic [LVL_W-1:0]               level;

	logic [phbd_pkg::BAND_W-1:0]    out_band_q;
	logic [phbd_pkg::OUT_LVL_W-1:0] bar_q;
	logic [phbd_pkg::OUT_LVL_W-1:0] peak_q;
	logic                           last_q;

	// Capture the accepted transaction and register the scaled product in the next cycle
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			band_q    <= in_band;
			band_ok_q <= (32'(in_band) < phbd_pkg::BANDS);
			sample_q  <= in_sample;
		end
		prod_s1 <= phbd_pkg::PROD_W'(sample_q) * phbd_pkg::PROD_W'(cfg.bar_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			phbd_pkg::RD_BAND: rd_addr = BAND_AW'(band_q);
			phbd_pkg::RD_IDX:  rd_addr = idx_q;
			phbd_pkg::RD_NEXT: rd_addr = idx_q + 1'b1;
			default:           rd_addr = idx_q;
		endcase
	end

	assign wr_addr = cmd.tk_wr ? idx_q : BAND_AW'(band_q);
	assign wr_en   = cmd.tk_wr | (cmd.ld_wr & band_ok_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_s <= mem[rd_addr];
		end
	end

	// An entry never written reads as its reset row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_s  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rvld_s <= valid_q[rd_addr];
			end
		end
	end

	assign row_cur = rvld_s ? rdata_s : phbd_pkg::ROW_RST;

	// Round up: ceil(product / 2^16), then saturate to the level range
	always_comb begin
		round_sum = {1'b0, prod_s1} + (phbd_pkg::PROD_W + 1)'(phbd_pkg::ROUND_ADD);
		scaled    = round_sum[phbd_pkg::PROD_W:phbd_pkg::FRAC_W];
		if (32'(scaled) > 32'(phbd_pkg::LEVEL_MAX)) begin
			level = phbd_pkg::LEVEL_MAX;
		end else begin
			level = LVL_W'(scaled);
		end
	end

	always_comb begin
		ld_row = row_cur;
		if (level > row_cur.bar) begin
			ld_row.bar       = level;
			ld_row.bar_step  = '0;
			ld_row.peak_step = '0;
		end
		if (level > row_cur.peak) begin
			ld_row.peak      = level;
			ld_row.hold      = '0;
			ld_row.peak_step = '0;
		end
	end

	always_comb begin
		tk_row          = row_cur;
		tk_row.bar      = fall(row_cur.bar, row_cur.bar_step);
		tk_row.bar_step = grow(row_cur.bar_step);
		if (row_cur.hold >= cfg.hold_ticks) begin
			tk_row.peak      = fall(row_cur.peak, row_cur.peak_step);
			tk_row.peak_step = grow(row_cur.peak_step);
		end
		if (row_cur.hold != phbd_pkg::HOLD_MAX) begin
			tk_row.hold = row_cur.hold + 1'b1;
		end
	end

	assign wdata = cmd.tk_wr ? tk_row : ld_row;

	assign sts.idx_last     = (32'(idx_q) == phbd_pkg::BANDS - 1);
	assign sts.idx_rep      = (32'(idx_q) < phbd_pkg::REPORT_N);
	assign sts.idx_rep_last = (32'(idx_q) == phbd_pkg::REPORT_N - 1);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_band_q <= phbd_pkg::BAND_W'(idx_q);
			bar_q      <= phbd_pkg::OUT_LVL_W'(tk_row.bar);
			peak_q     <= phbd_pkg::OUT_LVL_W'(tk_row.peak);
			last_q     <= sts.idx_rep_last;
		end
	end

	assign out_band   = out_band_q;
	assign bar_level  = bar_q;
	assign peak_level = peak_q;
	assign last       = last_q;

endmodule

### rtl/phbd_ctrl.sv
// Controller: sequences load and tick transactions and owns the result valid flag.
`include "peak_hold_bar_decay_top_assert.svh"

module phbd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_op,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  phbd_pkg::sts_t  sts,
	output phbd_pkg::cmd_t  cmd
);

	phbd_pkg::state_t state_q;
	phbd_pkg::state_t state_d;
	logic             out_valid_q;
	logic             advance;
	logic             out_open;
	logic             tick_done;
	logic             ld_rd;

	// Unreported bands never wait on the result register
	assign advance = ~sts.idx_rep | ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phbd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = phbd_pkg::RD_IDX;
		in_ready   = 1'b0;
		unique case (state_q)
			phbd_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (in_op == phbd_pkg::OP_TICK) begin
						cmd.idx_clr = 1'b1;
						state_d     = phbd_pkg::S_TK_RD;
					end else begin
						state_d = phbd_pkg::S_LD_RD;
					end
				end
			end
			phbd_pkg::S_LD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = phbd_pkg::RD_BAND;
				state_d    = phbd_pkg::S_LD_WR;
			end
			phbd_pkg::S_LD_WR: begin
				cmd.ld_wr = 1'b1;
				state_d   = phbd_pkg::S_IDLE;
			end
			phbd_pkg::S_TK_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = phbd_pkg::RD_IDX;
				state_d    = phbd_pkg::S_TK_RUN;
			end
			phbd_pkg::S_TK_RUN: begin
				// Write back band idx and, unless it is the last, prefetch the next band in the same cycle
				if (advance) begin
					cmd.tk_wr    = 1'b1;
					cmd.out_load = sts.idx_rep;
					if (sts.idx_last) begin
						state_d = phbd_pkg::S_IDLE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_sel  = phbd_pkg::RD_NEXT;
						cmd.idx_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = phbd_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	assign out_open  = ~out_valid_q | out_ready;
	assign tick_done = (state_q == phbd_pkg::S_TK_RUN) & cmd.tk_wr & sts.idx_last;
	assign ld_rd     = (state_q == phbd_pkg::S_LD_RD);

	`PHBD_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.out_load, out_open, "result overwritten")
	`PHBD_ASSERT_NEXT(a_tick_ends, clk, arst_n, tick_done, (state_q == phbd_pkg::S_IDLE), "sweep overran")
	`PHBD_ASSERT_NEXT(a_load_writes, clk, arst_n, ld_rd, (cmd.ld_wr && !cmd.tk_wr), "no load write back")

endmodule
